FILE: rtl/core/tqp_pkg.sv
// ----------------------------------------------------------------------------
// tqp_pkg
// shared widths, arithmetic constants and code values for the ternary
// quantizer and its multiply-add unit
// ----------------------------------------------------------------------------
package tqp_pkg;

  // datapath widths
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int CNT_OUT_W = 5;

  // default packing factor
  localparam int CODES_PER_WORD = 16;

  // lcg and threshold constants
  localparam logic [DATA_W-1:0] LCG_MUL          = 32'd1103515245;
  localparam logic [DATA_W-1:0] LCG_ADD          = 32'd12345;
  localparam logic [DATA_W-1:0] LCG_DEFAULT_SEED = 32'h1234_5678;
  localparam logic [DATA_W-1:0] T_HALF           = 32'h8000_0000;
  localparam logic [DATA_W-1:0] T_BASE           = 32'd1932735283;
  localparam logic [DATA_W-1:0] T_SPAN           = 32'd429496730;

  // ternary codes
  localparam logic [1:0] CODE_NEG  = 2'd0;
  localparam logic [1:0] CODE_ZERO = 2'd1;
  localparam logic [1:0] CODE_POS  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_MODE  = 2'd1;
  localparam logic [1:0] REG_SEED  = 2'd2;

endpackage

FILE: rtl/core/tqp_mac.sv
// ----------------------------------------------------------------------------
// tqp_mac
// shared unsigned multiply-add, p = a * b + c, result registered when enabled
// ----------------------------------------------------------------------------
module tqp_mac (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tqp_pkg::DATA_W-1:0] a,
  input  logic [tqp_pkg::DATA_W-1:0] b,
  input  logic [tqp_pkg::PROD_W-1:0] c,
  output logic [tqp_pkg::PROD_W-1:0] p
);
  import tqp_pkg::*;

  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;

  // one multiply and one add per cycle while en is high
  assign p_nxt = (PROD_W'(a) * PROD_W'(b)) + c;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

FILE: rtl/core/ternary_quantize_pack.sv
// ----------------------------------------------------------------------------
// ternary_quantize_pack
// quantizes signed q16.16 weights to 2-bit ternary codes and packs them
// lsb-first into 32-bit words, with optional lcg-dithered thresholds
// ----------------------------------------------------------------------------
//
//  channel | direction | ports                                      | beat
//  --------+-----------+--------------------------------------------+---------------------
//  in      | input     | in_valid/in_ready, weight, last_weight     | one weight
//  out     | output    | out_valid/out_ready, packed_word, codes,   | one packed word
//          |           | last_word                                  |
//  cfg     | input     | cfg_valid/cfg_ready, cfg_index, cfg_data   | one register write
//
//  a weight goes through accept, scale product and compare in fixed-threshold
//  mode and through accept, lcg step, threshold, scale product and compare in
//  dithered mode, all products going through the one shared multiply-add unit.
//  synchronous active-low reset restores the state, lcg, configuration, word,
//  slot count and output valid and marks the next weight as a tensor start.
//  a finished word sits in the output register; the compare step waits only
//  when a new word is due while the previous one is still not taken.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ternary_quantize_pack #(
  parameter int CODES_PER_WORD = tqp_pkg::CODES_PER_WORD
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input weights
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [tqp_pkg::DATA_W-1:0] in_weight,
  input  logic                         in_last_weight,
  // packed words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tqp_pkg::DATA_W-1:0]   out_packed_word,
  output logic [tqp_pkg::CNT_OUT_W-1:0] out_codes_in_word,
  output logic                         out_last_word,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [tqp_pkg::DATA_W-1:0]   cfg_data
);
  import tqp_pkg::*;

  localparam int CNT_W = $clog2(CODES_PER_WORD + 1);
  localparam int SLOTS_IN_WORD = DATA_W / 2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LCG  = 5'b00010,
    ST_THR  = 5'b00100,
    ST_SCL  = 5'b01000,
    ST_CMP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [DATA_W-1:0] scale_r;
  logic              mode_r;
  logic [DATA_W-1:0] seed_r;

  // per-weight and tensor state
  logic [DATA_W-1:0] weight_r;
  logic              last_r;
  logic              stoch_r;
  logic [DATA_W-1:0] lcg_r;
  logic [DATA_W-1:0] acc_r;
  logic [CNT_W-1:0]  slot_r;
  logic              tstart_r;

  // output register
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_word_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_last_r;

  // shared unit operands
  logic              mac_en;
  logic [DATA_W-1:0] mac_a;
  logic [DATA_W-1:0] mac_b;
  logic [PROD_W-1:0] mac_c;
  logic [PROD_W-1:0] mac_p;

  logic              in_fire;
  logic              out_fire;
  logic [DATA_W-1:0] mag;
  logic [DATA_W-1:0] scale_eff;
  logic [1:0]        code;
  logic [CNT_W-1:0]  slot_inc;
  logic [DATA_W-1:0] acc_new;
  logic              emit;
  logic              cmp_stall;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 32'd65536;
      mode_r  <= 1'b0;
      seed_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE: scale_r <= cfg_data;
        REG_MODE:  mode_r  <= cfg_data[0];
        REG_SEED:  seed_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiply-add operand selection
  assign scale_eff = (scale_r == '0) ? DATA_W'(1) : scale_r;

  always_comb begin
    mac_en = 1'b0;
    mac_a  = '0;
    mac_b  = '0;
    mac_c  = '0;
    unique case (state_r)
      ST_LCG: begin
        // next lcg value in the low word
        mac_en = 1'b1;
        mac_a  = lcg_r;
        mac_b  = LCG_MUL;
        mac_c  = PROD_W'(LCG_ADD);
      end
      ST_THR: begin
        // threshold lands in bits 62:31
        mac_en = 1'b1;
        mac_a  = {1'b0, mac_p[DATA_W-2:0]};
        mac_b  = T_SPAN;
        mac_c  = PROD_W'(T_BASE) << (DATA_W - 1);
      end
      ST_SCL: begin
        mac_en = 1'b1;
        mac_a  = scale_eff;
        mac_b  = stoch_r ? mac_p[PROD_W-2:DATA_W-1] : T_HALF;
        mac_c  = '0;
      end
      ST_IDLE, ST_CMP: ;
      default: ;
    endcase
  end

  tqp_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .p   (mac_p)
  );

  // compare magnitude against scale times threshold
  assign mag  = weight_r[DATA_W-1] ? (~weight_r + DATA_W'(1)) : weight_r;
  always_comb begin
    if ({mag, {DATA_W{1'b0}}} > mac_p) begin
      code = weight_r[DATA_W-1] ? CODE_NEG : CODE_POS;
    end else begin
      code = CODE_ZERO;
    end
  end

  // packing
  assign slot_inc = slot_r + CNT_W'(1);
  always_comb begin
    acc_new = acc_r;
    if (32'(slot_r) < SLOTS_IN_WORD) begin
      acc_new = acc_r | (DATA_W'(code) << {slot_r, 1'b0});
    end
  end
  assign emit      = (32'(slot_inc) >= CODES_PER_WORD) || last_r;
  assign cmp_stall = emit && out_valid_r && !out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = mode_r ? ST_LCG : ST_SCL;
      ST_LCG:  state_nxt = ST_THR;
      ST_THR:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_CMP;
      ST_CMP:  if (!cmp_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      weight_r <= unsigned'(in_weight);
      last_r   <= in_last_weight;
      stoch_r  <= mode_r;
    end
  end

  // lcg: reseed at tensor start, advance after the lcg step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r <= '0;
    end else if (in_fire && tstart_r) begin
      lcg_r <= (seed_r != '0) ? seed_r : LCG_DEFAULT_SEED;
    end else if (state_r == ST_THR) begin
      lcg_r <= mac_p[DATA_W-1:0];
    end
  end

  // word accumulator, slot count and tensor start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      slot_r   <= '0;
      tstart_r <= 1'b1;
    end else begin
      if (in_fire) begin
        tstart_r <= 1'b0;
      end
      if (state_r == ST_CMP && !cmp_stall) begin
        if (emit) begin
          acc_r  <= '0;
          slot_r <= '0;
          if (last_r) begin
            tstart_r <= 1'b1;
          end
        end else begin
          acc_r  <= acc_new;
          slot_r <= slot_inc;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_CMP && emit && !cmp_stall) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CMP && emit && !cmp_stall) begin
      out_word_r <= acc_new;
      out_cnt_r  <= CNT_OUT_W'(slot_inc);
      out_last_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packed_word   = out_word_r;
  assign out_codes_in_word = out_cnt_r;
  assign out_last_word     = out_last_r;

endmodule
